// ===== rtl/ssfe_pkg.sv =====
// Shared types and constants of the spectral shaping filter energy core.
package ssfe_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned ENERGY_W   = 63;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Longest committed block; longer settings are clamped to it.
  localparam logic [LEN_W-1:0] BLOCK_MAX       = 7'd64;
  localparam logic [LEN_W-1:0] BLOCK_LEN_RESET = 7'd2;

  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_PROBE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_B0   = 3'd0,
    CFG_COEF_B1   = 3'd1,
    CFG_COEF_B2   = 3'd2,
    CFG_COEF_B3   = 3'd3,
    CFG_BLOCK_LEN = 3'd4
  } cfg_index_e;

  typedef enum logic [1:0] {
    OP_COMMIT   = 2'd0,
    OP_PROBE    = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e                     opcode;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        run_last;
  } in_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic                kind;
    logic                saturated;
  } out_item_t;

  // Work classes handed from the front end to the execution unit.
  typedef enum logic [1:0] {
    CMD_COMMIT     = 2'd0,
    CMD_PROBE      = 2'd1,
    CMD_PROBE_HOLD = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                  kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       run_last;
  } cmd_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] b3;
  } coef_t;

endpackage

// ===== rtl/ssfe_front.sv =====
// Front end: accepts input items, drops no-ops and classifies the rest.
module ssfe_front (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ssfe_pkg::in_item_t          in_item_i,
  input  logic [ssfe_pkg::LEN_W-1:0]  block_length_i,
  input  logic                        queue_full_i,
  output logic                        push_o,
  output ssfe_pkg::cmd_t              cmd_o,
  output logic [ssfe_pkg::LEN_W-1:0]  len_o
);
  import ssfe_pkg::*;

  logic keep;

  assign len_o = (block_length_i > BLOCK_MAX) ? BLOCK_MAX : block_length_i;

  always_comb begin
    cmd_o.sample   = in_item_i.sample;
    cmd_o.run_last = in_item_i.run_last;
    cmd_o.kind     = CMD_CLEAR;
    keep           = 1'b0;
    unique case (in_item_i.opcode)
      OP_COMMIT: begin
        cmd_o.kind = CMD_COMMIT;
        keep       = (len_o != '0);
      end
      OP_PROBE: begin
        // With a zero block length a probe only opens or closes its run.
        cmd_o.kind = (len_o != '0) ? CMD_PROBE : CMD_PROBE_HOLD;
        keep       = 1'b1;
      end
      OP_CLEAR: begin
        cmd_o.kind = CMD_CLEAR;
        keep       = 1'b1;
      end
      OP_RESERVED: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i && keep;

endmodule

// ===== rtl/ssfe_queue.sv =====
// Short command queue between the front end and the execution unit.
module ssfe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssfe_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ssfe_pkg::cmd_t data_o
);
  import ssfe_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ssfe_back.sv =====
// Execution unit: filter sections, energy accumulation and result register.
module ssfe_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  ssfe_pkg::cmd_t             cmd_i,
  output logic                       pop_o,
  input  ssfe_pkg::coef_t            coef_i,
  input  logic [ssfe_pkg::LEN_W-1:0] len_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ssfe_pkg::out_item_t        out_item_o
);
  import ssfe_pkg::*;

  localparam int unsigned SEC_W     = 32;
  localparam int unsigned ACC_W     = 52;
  localparam int unsigned MUL_W     = 2 * SEC_W;
  localparam int unsigned RND_SHIFT = 14;
  localparam int unsigned X_SHIFT   = 22;
  localparam int unsigned PIN_SHIFT = 8;
  localparam int unsigned HI_MSB    = ACC_W - RND_SHIFT - SEC_W;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2 ** (RND_SHIFT - 1));

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SEC1 = 7'b0000010,
    ST_MID  = 7'b0000100,
    ST_SEC2 = 7'b0001000,
    ST_OUT  = 7'b0010000,
    ST_SQ   = 7'b0100000,
    ST_ACC  = 7'b1000000
  } state_e;

  // Drops 14 fraction bits and clamps to 32 bits; the top bit flags a clamp.
  function automatic logic [SEC_W:0] sat_shift(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-RND_SHIFT-1:0] r;
    logic [HI_MSB:0]            hi;
    logic [SEC_W:0]             res;
    r  = v[ACC_W-1:RND_SHIFT];
    hi = r[ACC_W-RND_SHIFT-1:SEC_W-1];
    if ((&hi) || !(|hi)) begin
      res = {1'b0, r[SEC_W-1:0]};
    end else if (hi[HI_MSB]) begin
      res = {1'b1, 1'b1, {(SEC_W-1){1'b0}}};
    end else begin
      res = {1'b1, 1'b0, {(SEC_W-1){1'b1}}};
    end
    return res;
  endfunction

  state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] kept_pin_q, probe_pin_q;
  logic signed [SEC_W-1:0]    kept_mid_q, kept_out_q, probe_mid_q, probe_out_q;
  logic [ENERGY_W-1:0]        kept_en_q, probe_en_q;
  logic                       probe_active_q;
  logic [LEN_W-1:0]           pos_q;
  logic                       sat_q;

  logic signed [SAMPLE_W-1:0] w_x_q;
  logic signed [SEC_W-1:0]    w_mid_q, w_out_q, mid_q, out_q;
  logic [ENERGY_W-1:0]        w_en_q;
  logic                       w_probe_q, w_last_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [MUL_W-1:0]    p_q;

  logic                       out_valid_q;
  out_item_t                  out_item_q, out_item_d;

  logic                       use_kept;
  logic signed [SAMPLE_W-1:0] src_pin;
  logic signed [SEC_W-1:0]    src_mid, src_out;
  logic [ENERGY_W-1:0]        src_en;
  logic signed [SEC_W-1:0]    mul_a, mul_b;
  logic signed [MUL_W-1:0]    product;
  logic                       mul_en;
  logic signed [ACC_W-1:0]    sec1_sum, sec2_sum, fin_sum;
  logic [SEC_W:0]             fin_res;
  logic [ENERGY_W:0]          en_sum;
  logic                       en_sat, sat_all;
  logic [ENERGY_W-1:0]        en_new;
  logic [LEN_W:0]             pos_inc;
  logic                       need_emit, out_free, acc_go;
  logic                       emit_hold, emit_acc, out_load;
  logic                       is_filter;

  // A commit, or the first sample of a probe run, starts from the kept state.
  assign use_kept = (cmd_i.kind == CMD_COMMIT) || !probe_active_q;
  assign src_pin  = use_kept ? kept_pin_q : probe_pin_q;
  assign src_mid  = use_kept ? kept_mid_q : probe_mid_q;
  assign src_out  = use_kept ? kept_out_q : probe_out_q;
  assign src_en   = use_kept ? kept_en_q  : probe_en_q;

  assign is_filter = (cmd_i.kind == CMD_COMMIT) || (cmd_i.kind == CMD_PROBE);

  // One shared multiplier serves all five products of a sample.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        mul_a = SEC_W'(src_pin);
        mul_b = SEC_W'(coef_i.b2);
      end
      ST_SEC1: begin
        mul_a = w_mid_q;
        mul_b = SEC_W'(coef_i.b0);
      end
      ST_MID: begin
        mul_a = w_mid_q;
        mul_b = SEC_W'(coef_i.b3);
      end
      ST_SEC2: begin
        mul_a = w_out_q;
        mul_b = SEC_W'(coef_i.b1);
      end
      ST_SQ: begin
        mul_a = out_q;
        mul_b = out_q;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign product = MUL_W'(mul_a) * MUL_W'(mul_b);

  assign sec1_sum = (ACC_W'(w_x_q) <<< X_SHIFT) - (ACC_W'(p_q) <<< PIN_SHIFT) + ROUND_BIAS;
  assign sec2_sum = (ACC_W'(mid_q) <<< RND_SHIFT) - ACC_W'(p_q) + ROUND_BIAS;
  assign fin_sum  = acc_q + ACC_W'(p_q);
  assign fin_res  = sat_shift(fin_sum);

  // The square of a 32-bit value is never negative and fits in 63 bits.
  assign en_sum  = {1'b0, w_en_q} + {1'b0, p_q[ENERGY_W-1:0]};
  assign en_sat  = en_sum[ENERGY_W];
  assign en_new  = en_sat ? {ENERGY_W{1'b1}} : en_sum[ENERGY_W-1:0];
  assign sat_all = sat_q | en_sat;

  assign pos_inc   = {1'b0, pos_q} + (LEN_W + 1)'(1);
  assign need_emit = w_probe_q ? w_last_q : (pos_inc >= {1'b0, len_i});
  assign out_free  = !out_valid_q || !out_stall_i;
  assign acc_go    = !need_emit || out_free;

  always_comb begin
    pop_o = 1'b0;
    if (state_q == ST_IDLE && cmd_valid_i) begin
      if (cmd_i.kind == CMD_PROBE_HOLD) begin
        pop_o = !cmd_i.run_last || out_free;
      end else begin
        pop_o = 1'b1;
      end
    end
  end

  assign emit_hold = (state_q == ST_IDLE) && pop_o && (cmd_i.kind == CMD_PROBE_HOLD) &&
                     cmd_i.run_last;
  assign emit_acc  = (state_q == ST_ACC) && acc_go && need_emit;
  assign out_load  = emit_hold || emit_acc;

  always_comb begin
    if (state_q == ST_ACC) begin
      out_item_d.energy    = en_new;
      out_item_d.kind      = w_probe_q ? KIND_PROBE : KIND_BLOCK;
      out_item_d.saturated = sat_all;
    end else begin
      out_item_d.energy    = probe_active_q ? probe_en_q : kept_en_q;
      out_item_d.kind      = KIND_PROBE;
      out_item_d.saturated = sat_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pop_o && is_filter) state_d = ST_SEC1;
      ST_SEC1: state_d = ST_MID;
      ST_MID:  state_d = ST_SEC2;
      ST_SEC2: state_d = ST_OUT;
      ST_OUT:  state_d = ST_SQ;
      ST_SQ:   state_d = ST_ACC;
      ST_ACC:  if (acc_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      kept_pin_q     <= '0;
      kept_mid_q     <= '0;
      kept_out_q     <= '0;
      kept_en_q      <= '0;
      probe_pin_q    <= '0;
      probe_mid_q    <= '0;
      probe_out_q    <= '0;
      probe_en_q     <= '0;
      probe_active_q <= 1'b0;
      pos_q          <= '0;
      sat_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o && cmd_i.kind == CMD_CLEAR) begin
            kept_pin_q     <= '0;
            kept_mid_q     <= '0;
            kept_out_q     <= '0;
            kept_en_q      <= '0;
            probe_pin_q    <= '0;
            probe_mid_q    <= '0;
            probe_out_q    <= '0;
            probe_en_q     <= '0;
            probe_active_q <= 1'b0;
            pos_q          <= '0;
            sat_q          <= 1'b0;
          end else if (pop_o && cmd_i.kind == CMD_PROBE_HOLD) begin
            if (!probe_active_q) begin
              probe_pin_q <= kept_pin_q;
              probe_mid_q <= kept_mid_q;
              probe_out_q <= kept_out_q;
              probe_en_q  <= kept_en_q;
            end
            probe_active_q <= !cmd_i.run_last;
            if (cmd_i.run_last) begin
              sat_q <= 1'b0;
            end
          end
        end
        ST_MID, ST_OUT: begin
          if (fin_res[SEC_W]) begin
            sat_q <= 1'b1;
          end
        end
        ST_ACC: begin
          if (acc_go) begin
            if (w_probe_q) begin
              probe_pin_q    <= w_x_q;
              probe_mid_q    <= mid_q;
              probe_out_q    <= out_q;
              probe_en_q     <= en_new;
              probe_active_q <= !w_last_q;
            end else begin
              kept_pin_q <= w_x_q;
              kept_mid_q <= mid_q;
              kept_out_q <= out_q;
              kept_en_q  <= en_new;
              pos_q      <= need_emit ? '0 : pos_inc[LEN_W-1:0];
            end
            sat_q <= need_emit ? 1'b0 : sat_all;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_q <= product;
    end
    if (out_load) begin
      out_item_q <= out_item_d;
    end
    unique case (state_q)
      ST_IDLE: begin
        w_x_q     <= cmd_i.sample;
        w_probe_q <= (cmd_i.kind == CMD_PROBE);
        w_last_q  <= cmd_i.run_last;
        w_mid_q   <= src_mid;
        w_out_q   <= src_out;
        w_en_q    <= src_en;
      end
      ST_SEC1: acc_q <= sec1_sum;
      ST_MID:  mid_q <= fin_res[SEC_W-1:0];
      ST_SEC2: acc_q <= sec2_sum;
      ST_OUT:  out_q <= fin_res[SEC_W-1:0];
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/spectral_shaping_filter_energy_core.sv =====
// Top level of the spectral shaping filter energy core.
//
// Input items carry an opcode (commit, probe, clear), a 16-bit sample and a
// run_last mark. Each commit or probe sample runs through two first-order
// sections and adds the squared output to an energy sum. A commit sample
// closes a block every block_length samples and then yields a result item
// with the kept energy; a probe run works on a copy of the kept state and
// yields its energy on the sample marked run_last. Clear yields nothing.
// Items that filter pass through the states IDLE, SEC1, MID, SEC2, OUT, SQ
// and ACC of the execution unit: one shared 32x32 multiplier is used five
// times per sample. Clear and probes at zero block length are handled in
// the IDLE state alone. A result is loaded into the output register from
// ACC, or from IDLE for a probe at zero block length.
// A two-entry queue sits between the front end and the execution unit, so
// new items are taken while a result waits in the output register. When
// the receiver stalls, the result holds and the execution unit stops only
// at the next item that has a result of its own to deliver.
// Reset clears all filter state, the coefficients to zero and the block
// length to two. The user must write configuration only while the core is idle; the core does not enforce this.
module spectral_shaping_filter_energy_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ssfe_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ssfe_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [ssfe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssfe_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ssfe_pkg::*;

  coef_t            coef_q;
  logic [LEN_W-1:0] block_len_q;
  logic [LEN_W-1:0] len_eff;
  logic             q_push, q_full, q_valid, q_pop;
  cmd_t             q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q      <= '0;
      block_len_q <= BLOCK_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COEF_B0:   coef_q.b0   <= cfg_data_i;
        CFG_COEF_B1:   coef_q.b1   <= cfg_data_i;
        CFG_COEF_B2:   coef_q.b2   <= cfg_data_i;
        CFG_COEF_B3:   coef_q.b3   <= cfg_data_i;
        CFG_BLOCK_LEN: block_len_q <= cfg_data_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssfe_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_item_i      (in_item_i),
    .block_length_i (block_len_q),
    .queue_full_i   (q_full),
    .push_o         (q_push),
    .cmd_o          (q_in),
    .len_o          (len_eff)
  );

  ssfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_out)
  );

  ssfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_out),
    .pop_o       (q_pop),
    .coef_i      (coef_q),
    .len_i       (len_eff),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("execution unit popped an empty queue");

  a_stall_means_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid)
    else $error("input stalled while the queue holds no item");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && !q_pop |=> q_valid)
    else $error("pushed item is missing from the queue");

endmodule

// ===== dv/spectral_shaping_filter_energy_checker.sv =====
// Checker of the spectral shaping filter energy core: predicts block and probe energies and compares.
module spectral_shaping_filter_energy_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  ssfe_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  ssfe_pkg::out_item_t             out_item_i,
  input  logic                            cfg_we_i,
  input  logic [ssfe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssfe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import ssfe_pkg::*;

  localparam longint Q8_MAX = (longint'(1) <<< 31) - 1;
  localparam longint Q8_MIN = -(longint'(1) <<< 31);
  localparam longint unsigned ENERGY_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic signed [SAMPLE_W-1:0] prev_in;
    logic signed [31:0]         prev_mid;
    logic signed [31:0]         prev_out;
    logic [ENERGY_W-1:0]        energy;
  } section_state_t;

  coef_t            gains;
  logic [LEN_W-1:0] blk_len;
  section_state_t   held_st;
  section_state_t   trial_st;
  logic             trial_open;
  int unsigned      block_fill;
  logic             sat_pending;
  out_item_t        energy_results_q[$];

  function automatic longint round_half_up(input longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  // Saturation of either section is remembered until the next result item.
  function automatic logic signed [31:0] clamp_q8(input longint v);
    if (v > Q8_MAX) begin
      sat_pending = 1'b1;
      return Q8_MAX[31:0];
    end
    if (v < Q8_MIN) begin
      sat_pending = 1'b1;
      return Q8_MIN[31:0];
    end
    return v[31:0];
  endfunction

  function automatic void run_sections(input logic signed [SAMPLE_W-1:0] x,
                                       inout section_state_t st);
    longint             acc;
    longint             acc2;
    logic signed [31:0] mid;
    logic signed [31:0] outv;
    longint unsigned    mag;
    longint unsigned    sum;
    acc = longint'(x) * 4194304
        - longint'(st.prev_in) * longint'(gains.b2) * 256
        + longint'(st.prev_mid) * longint'(gains.b0);
    mid = clamp_q8(round_half_up(acc));
    acc2 = longint'(mid) * 16384
         - longint'(st.prev_mid) * longint'(gains.b3)
         + longint'(st.prev_out) * longint'(gains.b1);
    outv = clamp_q8(round_half_up(acc2));
    if (outv < 0) mag = -longint'(outv);
    else mag = longint'(outv);
    sum = 64'(st.energy) + mag * mag;
    if (sum > ENERGY_TOP) begin
      sum = ENERGY_TOP;
      sat_pending = 1'b1;
    end
    st.energy   = sum[ENERGY_W-1:0];
    st.prev_in  = x;
    st.prev_mid = mid;
    st.prev_out = outv;
  endfunction

  function automatic void post_result(input logic [ENERGY_W-1:0] energy, input logic kind);
    out_item_t r;
    r.energy    = energy;
    r.kind      = kind;
    r.saturated = sat_pending;
    sat_pending = 1'b0;
    energy_results_q.push_back(r);
  endfunction

  function automatic void clear_filters();
    held_st     = '{default: '0};
    trial_st    = '{default: '0};
    trial_open  = 1'b0;
    block_fill  = 0;
    sat_pending = 1'b0;
  endfunction

  function automatic void predict_item(input in_item_t it);
    int unsigned eff_len;
    eff_len = 32'((blk_len > BLOCK_MAX) ? BLOCK_MAX : blk_len);
    case (it.opcode)
      OP_COMMIT: begin
        if (eff_len != 0) begin
          run_sections(it.sample, held_st);
          block_fill++;
          // A shortened block length closes the block at the next commit.
          if (block_fill >= eff_len) begin
            block_fill = 0;
            post_result(held_st.energy, KIND_BLOCK);
          end
        end
      end
      OP_PROBE: begin
        if (!trial_open) begin
          trial_st   = held_st;
          trial_open = 1'b1;
        end
        if (eff_len != 0) run_sections(it.sample, trial_st);
        if (it.run_last) begin
          trial_open = 1'b0;
          post_result(trial_st.energy, KIND_PROBE);
        end
      end
      OP_CLEAR: clear_filters();
      default: ;
    endcase
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (cfg_index_e'(idx))
      CFG_COEF_B0:   gains.b0 = data;
      CFG_COEF_B1:   gains.b1 = data;
      CFG_COEF_B2:   gains.b2 = data;
      CFG_COEF_B3:   gains.b3 = data;
      CFG_BLOCK_LEN: blk_len = data[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains   = '0;
      blk_len = BLOCK_LEN_RESET;
      clear_filters();
      energy_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // An item accepted in this cycle cannot be the source of a result
      // leaving in the same cycle, so the output side is checked first.
      if (out_valid_i && !out_stall_i) begin
        if (energy_results_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("unexpected result: energy %0d kind %b saturated %b",
                     out_item_i.energy, out_item_i.kind, out_item_i.saturated);
        end else begin
          out_item_t want;
          want = energy_results_q.pop_front();
          if (out_item_i.energy !== want.energy || out_item_i.kind !== want.kind ||
              out_item_i.saturated !== want.saturated) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT)
              $display("mismatch: energy exp %0d got %0d, kind exp %b got %b, %s",
                       want.energy, out_item_i.energy, want.kind, out_item_i.kind,
                       $sformatf("saturated exp %b got %b", want.saturated,
                                 out_item_i.saturated));
          end
        end
      end
      if (cfg_we_i) write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) predict_item(in_item_i);
      pending_o = energy_results_q.size();
    end
  end

endmodule

// ===== dv/spectral_shaping_filter_energy_core_tb.sv =====
// Testbench top of the spectral shaping filter energy core: stimulus, watchdog and verdict.
module spectral_shaping_filter_energy_core_tb;
  import ssfe_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [COEF_W-1:0]   COEF_MAX   = 16'sh7FFF;
  localparam logic signed [COEF_W-1:0]   COEF_MIN   = 16'sh8000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_count;
  int unsigned           pending;

  int unsigned      item_count;
  int unsigned      idle_cycles;
  int unsigned      burst_left;
  logic             gappy;
  logic             gaps_off;
  logic             long_hold_req;
  logic [LEN_W-1:0] cur_len;

  spectral_shaping_filter_energy_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  spectral_shaping_filter_energy_checker energy_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return SAMPLE_W'($urandom);
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return SAMPLE_W'(int'($urandom_range(0, 510)) - 255);
  endfunction

  // Mostly moderate gains keep the sections from saturating on every sample.
  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
      1: return '0;
      2: return COEF_W'($urandom);
      default: return COEF_W'(int'($urandom_range(0, 24000)) - 12000);
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return BLOCK_MAX;
    if (r == 3) return LEN_W'($urandom_range(65, 126));
    if (r < 6) return LEN_W'($urandom_range(9, 63));
    if (r < 10) return LEN_W'(1);
    return LEN_W'($urandom_range(2, 8));
  endfunction

  task automatic send(input opcode_e op, input logic signed [SAMPLE_W-1:0] s,
                      input logic last);
    int unsigned gap;
    int unsigned r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(4, 40);
      gappy = ($urandom_range(0, 2) != 0);
    end
    burst_left--;
    gap = 0;
    if (gappy && !gaps_off) begin
      r = $urandom_range(0, 99);
      if (r < 40) gap = 0;
      else if (r < 75) gap = $urandom_range(1, 2);
      else if (r < 95) gap = $urandom_range(3, 6);
      else gap = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= '{opcode: op, sample: s, run_last: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (op != OP_RESERVED && !(op == OP_COMMIT && cur_len == 0)) item_count++;
  endtask

  // Items without a result may still be in flight once the last result is out.
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic drive_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic set_config(input logic signed [COEF_W-1:0] b0, input logic signed [COEF_W-1:0] b1,
                            input logic signed [COEF_W-1:0] b2, input logic signed [COEF_W-1:0] b3,
                            input logic [LEN_W-1:0] len);
    drive_reg(CFG_COEF_B0, b0);
    drive_reg(CFG_COEF_B1, b1);
    drive_reg(CFG_COEF_B2, b2);
    drive_reg(CFG_COEF_B3, b3);
    drive_reg(CFG_BLOCK_LEN, CFG_DATA_W'(len));
    cfg_we <= 1'b0;
    cur_len = len;
  endtask

  task automatic traffic_step();
    int unsigned r;
    int unsigned k;
    logic        broken;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send(OP_COMMIT, pick_sample(), 1'($urandom));
    end else if (r < 80) begin
      // A probe run; now and then its closing mark is left off.
      k = $urandom_range(1, 6);
      broken = ($urandom_range(0, 9) == 0);
      for (int j = 0; j < k; j++)
        send(OP_PROBE, pick_sample(), (j == k - 1) && !broken);
    end else if (r < 86) begin
      send(OP_PROBE, pick_sample(), 1'($urandom));
    end else if (r < 90) begin
      send(OP_CLEAR, pick_sample(), 1'($urandom));
    end else if (r < 94) begin
      send(OP_RESERVED, pick_sample(), 1'($urandom));
    end else begin
      send(OP_COMMIT, ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN, 1'b0);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned phase_end;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    item_count    = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    gappy         = 1'b0;
    gaps_off      = 1'b0;
    long_hold_req = 1'b0;
    cur_len       = BLOCK_LEN_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: zero gains, blocks of two.
    send(OP_COMMIT, SAMPLE_MAX, 1'b0);
    send(OP_COMMIT, SAMPLE_MIN, 1'b0);
    send(OP_RESERVED, '1, 1'b1);
    send(OP_PROBE, 16'sd1, 1'b0);
    send(OP_PROBE, -16'sd1, 1'b1);

    // Extreme gains drive both sections and the energy into saturation.
    drain();
    set_config(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, 7'd1);
    repeat (4) send(OP_COMMIT, SAMPLE_MAX, 1'b0);
    send(OP_PROBE, SAMPLE_MIN, 1'b1);
    send(OP_CLEAR, SAMPLE_MAX, 1'b1);
    send(OP_COMMIT, '0, 1'b0);

    // Zero block length: commits do nothing, probes report without filtering.
    drain();
    set_config(16'sd8192, -16'sd8192, 16'sd16384, 16'sd4096, '0);
    send(OP_COMMIT, 16'sd1000, 1'b0);
    send(OP_PROBE, 16'sd5, 1'b0);
    send(OP_PROBE, 16'sd7, 1'b1);

    // Length above the maximum, then lowered in the middle of a block.
    drain();
    set_config(16'sd8192, -16'sd8192, 16'sd16384, 16'sd4096, '1);
    repeat (3) send(OP_COMMIT, pick_sample(), 1'b0);
    drain();
    set_config(16'sd8192, -16'sd8192, 16'sd16384, 16'sd4096, 7'd2);
    send(OP_COMMIT, pick_sample(), 1'b0);

    // Commits inside a probe run leave the run's copy alone.
    send(OP_PROBE, 16'sd10, 1'b0);
    send(OP_COMMIT, 16'sd20, 1'b0);
    send(OP_COMMIT, 16'sd30, 1'b0);
    send(OP_PROBE, 16'sd40, 1'b1);

    // Output held off while items keep coming, so the core backs up.
    drain();
    set_config(pick_coef(), pick_coef(), pick_coef(), pick_coef(), 7'd1);
    gaps_off = 1'b1;
    long_hold_req = 1'b1;
    repeat (30) send(OP_COMMIT, pick_sample(), 1'b0);
    gaps_off = 1'b0;

    target = item_count + RANDOM_ITEMS;
    while (item_count < target) begin
      drain();
      set_config(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_len());
      phase_end = item_count + PHASE_ITEMS;
      while (item_count < phase_end && item_count < target) traffic_step();
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Output side: random stalls with quiet stretches, plus one long hold on request.
  initial begin
    int unsigned calm_left;
    int unsigned r;
    out_stall = 1'b0;
    calm_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(15, 50)) @(negedge clk);
        end else if (r < 7) begin
          calm_left = $urandom_range(20, 120);
          out_stall <= 1'b0;
        end else begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/ssfe_pkg.sv
rtl/ssfe_front.sv
rtl/ssfe_queue.sv
rtl/ssfe_back.sv
rtl/spectral_shaping_filter_energy_core.sv
dv/spectral_shaping_filter_energy_checker.sv
dv/spectral_shaping_filter_energy_core_tb.sv
